// ===== rtl/bfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bfcc_pkg
// Shared types and constants of the bitmap font container checker.
// ----------------------------------------------------------------------------
package bfcc_pkg;

  localparam int unsigned GlyphDepth = 256;
  localparam int unsigned GlyphIdxW  = $clog2(GlyphDepth);
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw    = $clog2(QueueDepth);
  localparam int unsigned HeaderLen  = 24;
  localparam int unsigned RecordLen  = 20;

  localparam logic [15:0] ResetAtlasW = 16'd1024;
  localparam logic [15:0] ResetAtlasH = 16'd1024;
  localparam logic [8:0]  ResetGlyphN = 9'd256;
  localparam logic [15:0] ResetSide   = 16'd64;

  localparam logic [1:0] CFG_ATLAS_W = 2'd0;
  localparam logic [1:0] CFG_ATLAS_H = 2'd1;
  localparam logic [1:0] CFG_GLYPH_N = 2'd2;
  localparam logic [1:0] CFG_SIDE    = 2'd3;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_MAGIC    = 3'd1,
    ST_VERSION  = 3'd2,
    ST_HEADER   = 3'd3,
    ST_RESERVED = 3'd4,
    ST_INVALID  = 3'd5
  } status_e;

  typedef struct packed {
    logic [15:0] atlas_w;
    logic [15:0] atlas_h;
    logic [8:0]  glyph_n;
    logic [15:0] side;
  } cfg_t;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] descent;
    logic [15:0] ascent;
    logic [15:0] total;
    logic [15:0] height;
    logic [15:0] width;
    logic [2:0]  status;
  } result_t;

endpackage

// ===== rtl/bfcc_queue.sv =====
// ----------------------------------------------------------------------------
// bfcc_queue
// Short byte queue between the stream input and the checking engine.
// ----------------------------------------------------------------------------
module bfcc_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_valid_i,
  output logic                  wr_ready_o,
  input  bfcc_pkg::byte_item_t  wr_item_i,
  output logic                  rd_valid_o,
  input  logic                  rd_ready_i,
  output bfcc_pkg::byte_item_t  rd_item_o
);

  bfcc_pkg::byte_item_t              mem_q [bfcc_pkg::QueueDepth];
  logic [bfcc_pkg::QueueAw-1:0]      wr_ptr_q, rd_ptr_q;
  logic [bfcc_pkg::QueueAw:0]        cnt_q;
  logic                              push, pop;

  assign wr_ready_o = (cnt_q != (bfcc_pkg::QueueAw+1)'(bfcc_pkg::QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i & wr_ready_o;
  assign pop        = rd_valid_o & rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ===== rtl/bfcc_check.sv =====
// ----------------------------------------------------------------------------
// bfcc_check
// Parse engine: header, records with overlap scan, atlas, final status.
// ----------------------------------------------------------------------------
module bfcc_check (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bfcc_pkg::cfg_t        cfg_i,
  input  logic                  item_valid_i,
  output logic                  item_ready_o,
  input  bfcc_pkg::byte_item_t  item_i,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output bfcc_pkg::result_t     res_o
);

  typedef enum logic [2:0] {
    FS_RUN  = 3'b001,
    FS_SCAN = 3'b010,
    FS_DONE = 3'b100
  } fsm_e;

  localparam int unsigned Iw = bfcc_pkg::GlyphIdxW;

  fsm_e         state_q, state_d;
  logic [33:0]  pos_q;
  logic [7:0]   hdr_q [bfcc_pkg::HeaderLen];
  logic [7:0]   rec_q [bfcc_pkg::RecordLen-1];
  logic [4:0]   k_q;
  logic [16:0]  rec_cnt_q;
  logic [31:0]  prev_cp_q;
  logic [12:0]  col_q;
  logic [32:0]  seen_q;
  logic         mark_rsv_q, mark_glyph_q, mark_pad_q;
  logic         fin_q;
  logic [Iw-1:0] j_q, idx_q;
  logic         rd_valid_q;
  logic [63:0]  rd_data_q;
  logic [15:0]  cx_q, cy_q, cw_q, ch_q;
  logic [63:0]  rect_mem [bfcc_pkg::GlyphDepth];
  logic         rect_wr;
  bfcc_pkg::result_t res_q;
  logic         res_valid_q;

  logic         take, in_hdr, in_rec, rec_end, scan_end, finish;
  logic [15:0]  aw, ah, cnt, asc, dsc;
  logic [31:0]  blen, cp;
  logic [15:0]  rx, ry, rw, rh;
  logic         glyph_bad, overlap;
  logic [16:0]  stride_sum;
  logic [13:0]  stride;
  logic [7:0]   pad_mask;
  logic [33:0]  expected;
  logic [8:0]   limit;
  logic [29:0]  need_len;
  bfcc_pkg::status_e status;

  assign aw   = {hdr_q[9],  hdr_q[8]};
  assign ah   = {hdr_q[11], hdr_q[10]};
  assign cnt  = {hdr_q[13], hdr_q[12]};
  assign asc  = {hdr_q[15], hdr_q[14]};
  assign dsc  = {hdr_q[17], hdr_q[16]};
  assign blen = {hdr_q[23], hdr_q[22], hdr_q[21], hdr_q[20]};

  assign cp = {rec_q[3], rec_q[2], rec_q[1], rec_q[0]};
  assign rx = {rec_q[5], rec_q[4]};
  assign ry = {rec_q[7], rec_q[6]};
  assign rw = {rec_q[9], rec_q[8]};
  assign rh = {rec_q[11], rec_q[10]};

  assign stride_sum = {1'b0, aw} + 17'd7;
  assign stride     = stride_sum[16:3];
  assign pad_mask   = 8'hFF >> aw[2:0];

  assign item_ready_o = (state_q == FS_RUN);
  assign take    = item_valid_i & item_ready_o;
  assign in_hdr  = (pos_q < 34'(bfcc_pkg::HeaderLen));
  assign in_rec  = !in_hdr && (rec_cnt_q < {1'b0, cnt});
  assign rec_end = in_rec && (k_q == 5'(bfcc_pkg::RecordLen - 1));

  assign glyph_bad = (cp > 32'h10FFFF) || (cp >= 32'hD800 && cp <= 32'hDFFF) ||
                     (rw == '0) || (rh == '0) || (rw > cfg_i.side) || (rh > cfg_i.side) ||
                     ({1'b0, rx} + {1'b0, rw} > {1'b0, aw}) ||
                     ({1'b0, ry} + {1'b0, rh} > {1'b0, ah}) ||
                     ((rec_cnt_q != '0) && (prev_cp_q >= cp));

  // Stored rectangle: x in [15:0], y in [31:16], w in [47:32], h in [63:48]
  assign overlap = ({1'b0, rd_data_q[15:0]}  < {1'b0, cx_q} + {1'b0, cw_q}) &&
                   ({1'b0, cx_q} < {1'b0, rd_data_q[15:0]} + {1'b0, rd_data_q[47:32]}) &&
                   ({1'b0, rd_data_q[31:16]} < {1'b0, cy_q} + {1'b0, ch_q}) &&
                   ({1'b0, cy_q} < {1'b0, rd_data_q[31:16]} + {1'b0, rd_data_q[63:48]});

  assign scan_end = (state_q == FS_SCAN) && (j_q == idx_q) && !rd_valid_q;
  assign rect_wr  = scan_end;
  assign finish   = (state_q == FS_DONE) && (!res_valid_q || res_ready_i);

  assign expected = 34'(bfcc_pkg::HeaderLen) + {14'd0, cnt, 4'd0} + {16'd0, cnt, 2'd0}
                    + {2'd0, blen};
  assign limit    = (cfg_i.glyph_n > 9'(bfcc_pkg::GlyphDepth)) ?
                    9'(bfcc_pkg::GlyphDepth) : cfg_i.glyph_n;
  assign need_len = stride * ah;

  always_comb begin
    if (in_hdr || hdr_q[0] != "F" || hdr_q[1] != "G" || hdr_q[2] != "L" ||
        hdr_q[3] != "F") begin
      status = bfcc_pkg::ST_MAGIC;
    end else if ({hdr_q[5], hdr_q[4]} != 16'd1) begin
      status = bfcc_pkg::ST_VERSION;
    end else if ({hdr_q[7], hdr_q[6]} != 16'd1 || {hdr_q[19], hdr_q[18]} != '0 ||
                 expected != pos_q) begin
      status = bfcc_pkg::ST_HEADER;
    end else if (mark_rsv_q) begin
      status = bfcc_pkg::ST_RESERVED;
    end else if (aw == '0 || ah == '0 || aw > cfg_i.atlas_w || ah > cfg_i.atlas_h ||
                 cnt == '0 || cnt > {7'd0, limit} || asc[15] || dsc[15] ||
                 blen != {2'd0, need_len} || seen_q != {1'b0, blen} ||
                 mark_glyph_q || mark_pad_q) begin
      status = bfcc_pkg::ST_INVALID;
    end else begin
      status = bfcc_pkg::ST_OK;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FS_RUN: begin
        if (take && rec_end && (rec_cnt_q < 17'(bfcc_pkg::GlyphDepth))) state_d = FS_SCAN;
        else if (take && item_i.last) state_d = FS_DONE;
      end
      FS_SCAN: if (scan_end) state_d = fin_q ? FS_DONE : FS_RUN;
      FS_DONE: if (finish) state_d = FS_RUN;
      default: state_d = FS_RUN;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= rect_mem[j_q];
    if (rect_wr) rect_mem[idx_q] <= {ch_q, cw_q, cy_q, cx_q};
  end

  always_ff @(posedge clk_i) begin
    if (take && in_hdr) hdr_q[pos_q[4:0]] <= item_i.data;
    if (take && in_rec && !rec_end) rec_q[k_q] <= item_i.data;
    if (take && rec_end) begin
      cx_q  <= rx;
      cy_q  <= ry;
      cw_q  <= rw;
      ch_q  <= rh;
      idx_q <= rec_cnt_q[Iw-1:0];
    end
    if (finish) begin
      res_q.status  <= status;
      res_q.width   <= in_hdr ? '0 : aw;
      res_q.height  <= in_hdr ? '0 : ah;
      res_q.total   <= in_hdr ? '0 : cnt;
      res_q.ascent  <= in_hdr ? '0 : asc;
      res_q.descent <= in_hdr ? '0 : dsc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FS_RUN;
      pos_q        <= '0;
      k_q          <= '0;
      rec_cnt_q    <= '0;
      prev_cp_q    <= '0;
      col_q        <= '0;
      seen_q       <= '0;
      mark_rsv_q   <= 1'b0;
      mark_glyph_q <= 1'b0;
      mark_pad_q   <= 1'b0;
      fin_q        <= 1'b0;
      j_q          <= '0;
      rd_valid_q   <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (finish) res_valid_q <= 1'b1;
      else if (res_valid_q && res_ready_i) res_valid_q <= 1'b0;
      if (take) begin
        if (pos_q != '1) pos_q <= pos_q + 1'b1;
        if (item_i.last) fin_q <= 1'b1;
        if (in_rec) begin
          if (rec_end) begin
            k_q       <= '0;
            j_q       <= '0;
            prev_cp_q <= cp;
            if (rec_cnt_q != '1) rec_cnt_q <= rec_cnt_q + 1'b1;
            if ({item_i.data, rec_q[18]} != '0) mark_rsv_q <= 1'b1;
            if (glyph_bad) mark_glyph_q <= 1'b1;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end else if (!in_hdr) begin
          if (seen_q != '1) seen_q <= seen_q + 1'b1;
          if (stride != '0) begin
            if ({1'b0, col_q} >= stride - 14'd1) begin
              col_q <= '0;
              if ((aw[2:0] != '0) && ((item_i.data & pad_mask) != '0)) mark_pad_q <= 1'b1;
            end else begin
              col_q <= col_q + 1'b1;
            end
          end
        end
      end
      if (state_q == FS_SCAN) begin
        rd_valid_q <= (j_q != idx_q);
        if (j_q != idx_q) j_q <= j_q + 1'b1;
        if (rd_valid_q && overlap) mark_glyph_q <= 1'b1;
      end
      if (finish) begin
        pos_q        <= '0;
        k_q          <= '0;
        rec_cnt_q    <= '0;
        prev_cp_q    <= '0;
        col_q        <= '0;
        seen_q       <= '0;
        mark_rsv_q   <= 1'b0;
        mark_glyph_q <= 1'b0;
        mark_pad_q   <= 1'b0;
        fin_q        <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/bitmap_font_container_checker.sv =====
// ----------------------------------------------------------------------------
// bitmap_font_container_checker
// Streaming checker for bitmap font containers, one status per container.
// ----------------------------------------------------------------------------
// Bytes enter through a four-entry queue and are checked at one per cycle
// while no scan or status is pending: header, 20-byte glyph records and
// atlas bits. Each record whose index is below the 256-entry rectangle
// memory then goes through an overlap scan that reads one stored rectangle
// per cycle from that memory, with nothing to read for the first record.
// After the last byte (tlast) the status is formed; the result waits
// in an output register while the next container's bytes already queue up.
module bitmap_font_container_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  // config write: index 0 atlas width, 1 atlas height, 2 glyph count, 3 side
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [15:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,   // final_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [2:0] status, [18:3] atlas_width, [34:19] atlas_height,
  // [50:35] glyph_total, [66:51] ascent, [82:67] descent
  output logic [87:0]  m_axis_tdata
);

  bfcc_pkg::cfg_t        cfg_q;
  bfcc_pkg::byte_item_t  in_item, q_item;
  bfcc_pkg::result_t     res;
  logic                  q_valid, q_ready;

  // The user must change limits only between containers; the block does not enforce this and takes every transfer.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.atlas_w <= bfcc_pkg::ResetAtlasW;
      cfg_q.atlas_h <= bfcc_pkg::ResetAtlasH;
      cfg_q.glyph_n <= bfcc_pkg::ResetGlyphN;
      cfg_q.side    <= bfcc_pkg::ResetSide;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bfcc_pkg::CFG_ATLAS_W: cfg_q.atlas_w <= cfg_data_i;
        bfcc_pkg::CFG_ATLAS_H: cfg_q.atlas_h <= cfg_data_i;
        bfcc_pkg::CFG_GLYPH_N: cfg_q.glyph_n <= cfg_data_i[8:0];
        bfcc_pkg::CFG_SIDE:    cfg_q.side    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_item.data = s_axis_tdata;
  assign in_item.last = s_axis_tlast;

  // Front: hold up to four incoming bytes so the stream can keep flowing during a scan.
  bfcc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_axis_tvalid),
    .wr_ready_o (s_axis_tready),
    .wr_item_i  (in_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  // Back: parse and validate, then present one status transfer per container.
  bfcc_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .item_i       (q_item),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  assign m_axis_tdata = {5'd0, res};

endmodule
